// File: src/vsbdf_pkg.sv
package vsbdf_pkg;

  localparam int HIST_DEPTH = 3;
  localparam int NUM_COEF   = 7;
  localparam int COEF_W     = 32;
  localparam int STEP_W     = 32;
  localparam int OPW        = 35;   // widest operand: 2a+2b+c
  localparam int ACC_W      = 140;  // product << 33 plus headroom
  localparam int CNT_W      = 6;

  localparam logic [1:0]        MAX_ORDER_RST = 2'd3;
  localparam logic [STEP_W-1:0] INIT_STEP_RST = 32'h0001_0000;
  localparam logic [COEF_W-1:0] ONE_Q24       = 32'h0100_0000;
  localparam logic [COEF_W-1:0] MINUS_ONE_Q24 = 32'hFF00_0000;
  localparam logic [COEF_W-1:0] COEF_MAX      = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN      = 32'h8000_0000;

  typedef enum logic {
    CFG_MAX_ORDER = 1'b0,
    CFG_INIT_STEP = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ONE, OP_A, OP_B, OP_C, OP_S1, OP_S2, OP_S3, OP_S13
  } opnd_t;

  typedef struct packed {
    logic  zero;
    opnd_t nx;
    opnd_t ny;
    opnd_t nz;
    opnd_t dx;
    opnd_t dy;
    opnd_t dz;
    logic  add_den;
    logic  neg;
  } coef_spec_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [COEF_W-1:0] value;
  } coef_res_t;

  function automatic coef_spec_t mk(logic z, opnd_t nx, opnd_t ny, opnd_t nz,
                                    opnd_t dx, opnd_t dy, opnd_t dz,
                                    logic ad, logic ng);
    coef_spec_t s;
    s.zero = z; s.nx = nx; s.ny = ny; s.nz = nz;
    s.dx = dx; s.dy = dy; s.dz = dz; s.add_den = ad; s.neg = ng;
    return s;
  endfunction

  // num = (add_den ? den : 0) + nx*ny*nz, den = dx*dy*dz
  function automatic coef_spec_t coef_spec(logic ord3, logic [2:0] k);
    coef_spec_t s;
    s = mk(1'b1, OP_ONE, OP_ONE, OP_ONE, OP_ONE, OP_ONE, OP_ONE, 1'b0, 1'b0);
    if (!ord3) begin
      case (k)
        3'd0: s = mk(1'b0, OP_A, OP_ONE, OP_ONE, OP_S1, OP_ONE, OP_ONE, 1'b1, 1'b0);
        3'd1: s = mk(1'b0, OP_S1, OP_ONE, OP_ONE, OP_B, OP_ONE, OP_ONE, 1'b0, 1'b1);
        3'd2: s = mk(1'b0, OP_A, OP_A, OP_ONE, OP_B, OP_S1, OP_ONE, 1'b0, 1'b0);
        3'd4: s = mk(1'b0, OP_S1, OP_ONE, OP_ONE, OP_B, OP_ONE, OP_ONE, 1'b0, 1'b0);
        3'd5: s = mk(1'b0, OP_A, OP_ONE, OP_ONE, OP_B, OP_ONE, OP_ONE, 1'b0, 1'b1);
        default: ;
      endcase
    end else begin
      case (k)
        3'd0: s = mk(1'b0, OP_A, OP_S13, OP_ONE, OP_S1, OP_S3, OP_ONE, 1'b1, 1'b0);
        3'd1: s = mk(1'b0, OP_S1, OP_S3, OP_ONE, OP_B, OP_S2, OP_ONE, 1'b0, 1'b1);
        3'd2: s = mk(1'b0, OP_A, OP_A, OP_S3, OP_B, OP_C, OP_S1, 1'b0, 1'b0);
        3'd3: s = mk(1'b0, OP_A, OP_A, OP_S1, OP_C, OP_S2, OP_S3, 1'b0, 1'b1);
        3'd4: s = mk(1'b0, OP_S1, OP_S3, OP_ONE, OP_B, OP_S2, OP_ONE, 1'b0, 1'b0);
        3'd5: s = mk(1'b0, OP_A, OP_S3, OP_ONE, OP_B, OP_C, OP_ONE, 1'b0, 1'b1);
        3'd6: s = mk(1'b0, OP_A, OP_S1, OP_ONE, OP_C, OP_S2, OP_ONE, 1'b0, 1'b0);
        default: ;
      endcase
    end
    return s;
  endfunction

endpackage

// File: src/variable_step_bdf_ext_coefficients.sv
// Variable-step BDF and extrapolation coefficient generator. Each accepted
// beat carries a step index and a Q16.16 step size; the block picks the order
// min(step_index+1, max_order), works out bdf_c0..3 and ext_c1..3 as rounded,
// saturated Q8.24 values from the last three step sizes, shifts the new step
// size into the history as the beat is accepted, and returns one result beat.
// One shared 140-bit add/subtract unit does all the work: each nonzero
// coefficient is two shift-add triple products (den, then num) plus a
// restoring division. The input is stalled while a step is in work; a
// finished result waits in the output register while the next beat can
// already be taken. Writing initial_step_size also reloads history[0].
module variable_step_bdf_ext_coefficients import vsbdf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [STEP_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [15:0]              in_step_index,
  input  logic [STEP_W-1:0]        in_step_size,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] out_bdf_c0,
  output logic signed [COEF_W-1:0] out_bdf_c1,
  output logic signed [COEF_W-1:0] out_bdf_c2,
  output logic signed [COEF_W-1:0] out_bdf_c3,
  output logic signed [COEF_W-1:0] out_ext_c1,
  output logic signed [COEF_W-1:0] out_ext_c2,
  output logic signed [COEF_W-1:0] out_ext_c3,
  output logic [1:0]               out_order_used,
  output logic                     out_divide_error
);
  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT_UNIT, S_DONE} state_t;

  state_t            state_r;
  logic [1:0]        max_order_r;
  logic [STEP_W-1:0] hist_r [HIST_DEPTH];
  logic [STEP_W-1:0] a_r, b_r, c_r;
  logic [COEF_W-1:0] held_r [NUM_COEF];
  logic [COEF_W-1:0] nc_r   [NUM_COEF];
  logic [2:0]        k_r;
  logic              ord3_r, apply_r, err_r, out_valid_r, out_err_r, start_r;
  logic [1:0]        ord_r, out_ord_r;

  logic              in_acc;
  logic [1:0]        mo;
  logic [16:0]       step_p1;
  logic [1:0]        ord;
  logic              br1, br2, br3, zdiv;
  coef_spec_t        spec;
  coef_res_t         ures;
  logic              out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // order selection; a max order of zero acts as one
  always_comb begin
    mo      = (max_order_r == 2'd0) ? 2'd1 : max_order_r;
    step_p1 = {1'b0, in_step_index} + 17'd1;
    ord     = (step_p1 < {15'd0, mo}) ? step_p1[1:0] : mo;
    br1     = (in_step_index == 16'd0) && (ord == 2'd1);
    br2     = (in_step_index >= 16'd1) && (ord == 2'd2);
    br3     = (in_step_index >= 16'd2) && (ord == 2'd3);
    zdiv    = (br2 && hist_r[1] == '0) ||
              (br3 && (hist_r[1] == '0 || hist_r[2] == '0));
  end

  assign spec = coef_spec(ord3_r, k_r);

  vsbdf_coef_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .spec   (spec),
    .hist_a (a_r),
    .hist_b (b_r),
    .hist_c (c_r),
    .res    (ures)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_order_r <= MAX_ORDER_RST;
      hist_r[0]   <= INIT_STEP_RST;
      for (int i = 1; i < HIST_DEPTH; i++) hist_r[i] <= '0;
      for (int i = 0; i < NUM_COEF; i++) held_r[i] <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // drop the result once taken, unless a new one replaces it this edge
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      // configuration must arrive only while idle; the block does not enforce this
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MAX_ORDER: max_order_r <= cfg_wdata[1:0];
          CFG_INIT_STEP: hist_r[0]   <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: if (in_acc) begin
          // latch operands, shift history right away
          a_r    <= hist_r[0];
          b_r    <= hist_r[1];
          c_r    <= hist_r[2];
          for (int i = 1; i < HIST_DEPTH; i++) hist_r[i] <= hist_r[i-1];
          hist_r[0] <= in_step_size;
          ord_r  <= ord;
          ord3_r <= br3;
          k_r    <= '0;
          err_r  <= zdiv;
          if (br1) begin
            nc_r[0] <= ONE_Q24;
            nc_r[1] <= MINUS_ONE_Q24;
            nc_r[2] <= '0;
            nc_r[3] <= '0;
            nc_r[4] <= ONE_Q24;
            nc_r[5] <= '0;
            nc_r[6] <= '0;
          end
          apply_r <= br1 || ((br2 || br3) && !zdiv);
          state_r <= ((br2 || br3) && !zdiv) ? S_ISSUE : S_DONE;
        end
        S_ISSUE: begin
          if (spec.zero) begin
            nc_r[k_r] <= '0;
            k_r       <= k_r + 1'b1;
            state_r   <= (k_r == 3'(NUM_COEF - 1)) ? S_DONE : S_ISSUE;
          end else begin
            start_r <= 1'b1;
            state_r <= S_WAIT_UNIT;
          end
        end
        S_WAIT_UNIT: if (ures.done) begin
          nc_r[k_r] <= ures.value;
          err_r     <= err_r | ures.sat;
          k_r       <= k_r + 1'b1;
          state_r   <= (k_r == 3'(NUM_COEF - 1)) ? S_DONE : S_ISSUE;
        end
        S_DONE: if (out_free) begin
          // hold coefficients unless this step produced a new set
          if (apply_r) for (int i = 0; i < NUM_COEF; i++) held_r[i] <= nc_r[i];
          out_ord_r   <= ord_r;
          out_err_r   <= err_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bdf_c0       = $signed(held_r[0]);
  assign out_bdf_c1       = $signed(held_r[1]);
  assign out_bdf_c2       = $signed(held_r[2]);
  assign out_bdf_c3       = $signed(held_r[3]);
  assign out_ext_c1       = $signed(held_r[4]);
  assign out_ext_c2       = $signed(held_r[5]);
  assign out_ext_c3       = $signed(held_r[6]);
  assign out_order_used   = out_ord_r;
  assign out_divide_error = out_err_r;

`ifndef SYNTH
  a_order_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order_used != 2'd0)
    else $error("order_used zero on a result beat");

  a_unit_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ures.done |-> state_r == S_WAIT_UNIT)
    else $error("coefficient unit finished while not awaited");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start work");
`endif
endmodule

// File: src/vsbdf_alu.sv
module vsbdf_alu import vsbdf_pkg::*; (
  input  logic [ACC_W-1:0] op_a,
  input  logic [ACC_W-1:0] op_b,
  input  logic             sub,
  output logic [ACC_W-1:0] res,
  output logic             carry
);
  logic [ACC_W:0] sum;

  assign sum   = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{ACC_W{1'b0}}, sub};
  assign res   = sum[ACC_W-1:0];
  assign carry = sum[ACC_W];   // on subtract: op_a >= op_b
endmodule

// File: src/vsbdf_coef_unit.sv
module vsbdf_coef_unit import vsbdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  coef_spec_t        spec,
  input  logic [STEP_W-1:0] hist_a,
  input  logic [STEP_W-1:0] hist_b,
  input  logic [STEP_W-1:0] hist_c,
  output coef_res_t         res
);
  typedef enum logic [3:0] {
    U_IDLE, U_LOAD, U_MUL1, U_MID, U_MUL2, U_NEXT, U_PREP, U_SAT, U_DIV, U_FIN
  } ustate_t;

  ustate_t           state_r;
  coef_spec_t        spec_r;
  logic              num_ph_r, ovf_r, done_r, sat_r;
  logic [ACC_W-1:0]  acc_r, mcand_r, den_r, rem_r, dsr_r;
  logic [OPW-1:0]    mplier_r;
  logic [COEF_W-1:0] q_r, value_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [ACC_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_sub, alu_carry;

  function automatic logic [OPW-1:0] opnd_val(opnd_t o, logic [STEP_W-1:0] a,
                                              logic [STEP_W-1:0] b,
                                              logic [STEP_W-1:0] c);
    logic [OPW-1:0] ea, eb, ec;
    ea = {{(OPW-STEP_W){1'b0}}, a};
    eb = {{(OPW-STEP_W){1'b0}}, b};
    ec = {{(OPW-STEP_W){1'b0}}, c};
    case (o)
      OP_A:    return ea;
      OP_B:    return eb;
      OP_C:    return ec;
      OP_S1:   return ea + eb;
      OP_S2:   return eb + ec;
      OP_S3:   return ea + eb + ec;
      OP_S13:  return (ea << 1) + (eb << 1) + ec;
      default: return {{(OPW-1){1'b0}}, 1'b1};
    endcase
  endfunction

  always_comb begin
    alu_a   = acc_r;
    alu_b   = mcand_r;
    alu_sub = 1'b0;
    unique case (state_r)
      U_PREP: begin
        alu_a = acc_r << 25;
        alu_b = den_r;
      end
      U_SAT, U_DIV: begin
        alu_a   = rem_r;
        alu_b   = dsr_r;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  vsbdf_alu u_alu (
    .op_a  (alu_a),
    .op_b  (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: if (start) begin
          spec_r   <= spec;
          num_ph_r <= 1'b0;
          state_r  <= U_LOAD;
        end
        U_LOAD: begin
          mcand_r  <= {{(ACC_W-OPW){1'b0}},
                       opnd_val(num_ph_r ? spec_r.nx : spec_r.dx, hist_a, hist_b, hist_c)};
          mplier_r <= opnd_val(num_ph_r ? spec_r.ny : spec_r.dy, hist_a, hist_b, hist_c);
          acc_r    <= '0;
          cnt_r    <= CNT_W'(OPW - 1);
          state_r  <= U_MUL1;
        end
        U_MUL1, U_MUL2: begin
          if (mplier_r[0]) acc_r <= alu_res;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= (state_r == U_MUL1) ? U_MID : U_NEXT;
        end
        U_MID: begin
          mcand_r  <= acc_r;
          mplier_r <= opnd_val(num_ph_r ? spec_r.nz : spec_r.dz, hist_a, hist_b, hist_c);
          acc_r    <= (num_ph_r && spec_r.add_den) ? den_r : '0;
          cnt_r    <= CNT_W'(OPW - 1);
          state_r  <= U_MUL2;
        end
        U_NEXT: begin
          if (!num_ph_r) begin
            den_r    <= acc_r;
            num_ph_r <= 1'b1;
            state_r  <= U_LOAD;
          end else begin
            state_r <= U_PREP;
          end
        end
        U_PREP: begin
          // rem = num*2^25 + den, compare against 2*den*2^32 first
          rem_r   <= alu_res;
          dsr_r   <= den_r << 33;
          state_r <= U_SAT;
        end
        U_SAT: begin
          ovf_r <= alu_carry;
          q_r   <= '0;
          dsr_r <= dsr_r >> 1;
          cnt_r <= CNT_W'(COEF_W - 1);
          state_r <= alu_carry ? U_FIN : U_DIV;
        end
        U_DIV: begin
          if (alu_carry) rem_r <= alu_res;
          q_r   <= {q_r[COEF_W-2:0], alu_carry};
          dsr_r <= dsr_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= U_FIN;
        end
        U_FIN: begin
          if (ovf_r) begin
            sat_r   <= 1'b1;
            value_r <= spec_r.neg ? COEF_MIN : COEF_MAX;
          end else if (!spec_r.neg) begin
            sat_r   <= q_r > COEF_MAX;
            value_r <= (q_r > COEF_MAX) ? COEF_MAX : q_r;
          end else begin
            sat_r   <= q_r > COEF_MIN;
            value_r <= (q_r > COEF_MIN) ? COEF_MIN : (~q_r + 1'b1);
          end
          done_r  <= 1'b1;
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.sat   = sat_r;
  assign res.value = value_r;
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb import vsbdf_pkg::*; ();

  // One result beat: seven Q8.24 coefficients, the order and the error flag.
  typedef struct {
    logic [COEF_W-1:0] coef [NUM_COEF];
    logic [1:0]        order;
    logic              err;
  } coef_beat_t;

  // 192-bit scratch width: a triple product of 35-bit sums, shifted by 25
  // and then by 33 more for the saturation bound, still fits.
  typedef logic [191:0] wide_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 400;

  // Predicts each result beat from the accepted input beats and checks the
  // block's results against them in order.
  class coef_scoreboard;
    logic [1:0]        max_order;
    logic [STEP_W-1:0] history [HIST_DEPTH];
    logic [COEF_W-1:0] held [NUM_COEF];
    coef_beat_t        pending [$];
    int                errors;

    function new();
      max_order = MAX_ORDER_RST;
      history[0] = INIT_STEP_RST;
      history[1] = '0;
      history[2] = '0;
      foreach (held[i]) held[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [STEP_W-1:0] data);
      if (idx == CFG_MAX_ORDER) max_order = data[1:0];
      else history[0] = data;
    endfunction

    // Round num/den * 2^24 to nearest, ties away from zero, then clamp.
    function logic [COEF_W-1:0] quotient(wide_t num, wide_t den, bit neg, inout bit sat);
      wide_t rem, d2, q;
      rem = (num << 25) + den;
      d2  = den << 1;
      if (rem >= (d2 << 32)) begin
        sat = 1'b1;
        return neg ? COEF_MIN : COEF_MAX;
      end
      q = rem / d2;
      if (!neg) begin
        if (q > 192'h7FFF_FFFF) begin
          sat = 1'b1;
          return COEF_MAX;
        end
        return q[31:0];
      end
      if (q > 192'h8000_0000) begin
        sat = 1'b1;
        return COEF_MIN;
      end
      return 32'd0 - q[31:0];
    endfunction

    function void note_step(logic [15:0] step, logic [STEP_W-1:0] size);
      wide_t a, b, c, s1, s2, s3;
      logic [COEF_W-1:0] nc [NUM_COEF];
      int unsigned mo, ord;
      bit apply, err;
      coef_beat_t exp_beat;
      a = history[0]; b = history[1]; c = history[2];
      s1 = a + b; s2 = b + c; s3 = a + b + c;
      mo = (max_order == 0) ? 1 : max_order;
      ord = (step + 1 < mo) ? step + 1 : mo;
      apply = 0; err = 0;
      if (step == 0 && ord == 1) begin
        nc[0] = ONE_Q24; nc[1] = MINUS_ONE_Q24; nc[2] = '0; nc[3] = '0;
        nc[4] = ONE_Q24; nc[5] = '0; nc[6] = '0;
        apply = 1;
      end else if (step >= 1 && ord == 2) begin
        if (b == 0) err = 1;
        else begin
          nc[0] = quotient(s1 + a, s1, 0, err);
          nc[1] = quotient(s1, b, 1, err);
          nc[2] = quotient(a * a, b * s1, 0, err);
          nc[3] = '0;
          nc[4] = quotient(s1, b, 0, err);
          nc[5] = quotient(a, b, 1, err);
          nc[6] = '0;
          apply = 1;
        end
      end else if (step >= 2 && ord == 3) begin
        if (b == 0 || c == 0) err = 1;
        else begin
          nc[0] = quotient(s1 * s3 + a * s3 + a * s1, s1 * s3, 0, err);
          nc[1] = quotient(s1 * s3, b * s2, 1, err);
          nc[2] = quotient(a * a * s3, b * c * s1, 0, err);
          nc[3] = quotient(a * a * s1, c * s2 * s3, 1, err);
          nc[4] = quotient(s1 * s3, b * s2, 0, err);
          nc[5] = quotient(a * s3, b * c, 1, err);
          nc[6] = quotient(a * s1, c * s2, 0, err);
          apply = 1;
        end
      end
      if (apply) held = nc;
      exp_beat.coef  = held;
      exp_beat.order = ord[1:0];
      exp_beat.err   = err;
      pending.insert(pending.size(), exp_beat);
      // shift the new step size into the history, held or not
      history[2] = history[1];
      history[1] = history[0];
      history[0] = size;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(coef_beat_t got);
      coef_beat_t want;
      if (pending.size() == 0) begin
        report("result beat with no expectation waiting");
        return;
      end
      want = pending.pop_front();
      foreach (want.coef[i])
        if (got.coef[i] !== want.coef[i])
          report($sformatf("coef %0d got %h want %h", i, got.coef[i], want.coef[i]));
      if (got.order !== want.order)
        report($sformatf("order_used got %0d want %0d", got.order, want.order));
      if (got.err !== want.err)
        report($sformatf("divide_error got %b want %b", got.err, want.err));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [15:0]       in_step_index = '0;
  logic [STEP_W-1:0] in_step_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [COEF_W-1:0] out_bdf_c0, out_bdf_c1, out_bdf_c2, out_bdf_c3;
  logic signed [COEF_W-1:0] out_ext_c1, out_ext_c2, out_ext_c3;
  logic [1:0]        out_order_used;
  logic              out_divide_error;

  coef_scoreboard sb = new();
  int  idle_in = 0;   // percent of cycles the sender holds back
  int  idle_out = 0;  // percent of cycles the receiver stalls
  int  quiet_cycles = 0;
  bit  beat_moved;

  variable_step_bdf_ext_coefficients u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_step_index, .in_step_size,
    .out_valid, .out_stall,
    .out_bdf_c0, .out_bdf_c1, .out_bdf_c2, .out_bdf_c3,
    .out_ext_c1, .out_ext_c2, .out_ext_c3,
    .out_order_used, .out_divide_error
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: pick a fresh stall decision every falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < idle_out);
  end

  // Sample results at the rising edge; the watchdog counts cycles with no beat.
  always @(posedge clk) begin
    coef_beat_t got;
    beat_moved = 0;
    if (rst_n && out_valid && !out_stall) begin
      got.coef[0] = out_bdf_c0; got.coef[1] = out_bdf_c1;
      got.coef[2] = out_bdf_c2; got.coef[3] = out_bdf_c3;
      got.coef[4] = out_ext_c1; got.coef[5] = out_ext_c2;
      got.coef[6] = out_ext_c3;
      got.order = out_order_used;
      got.err   = out_divide_error;
      sb.check_result(got);
      beat_moved = 1;
    end
    if (rst_n && in_valid && !in_stall) beat_moved = 1;
    quiet_cycles = beat_moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** variable_step_bdf_ext_coefficients: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_step(logic [15:0] step, logic [STEP_W-1:0] size);
    while ($urandom_range(99) < idle_in) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_step_index = step;
    in_step_size = size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_step(step, size);
    @(negedge clk);
  endtask

  // Drain all outstanding results, let the block settle, then write a register.
  task automatic write_reg(cfg_idx_t idx, logic [STEP_W-1:0] data);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Mostly step sizes between one half and two, with extremes mixed in.
  function automatic logic [STEP_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(255);
      3: return 32'hFFFF_0000 | $urandom_range(32'hFFFF);
      default: return 32'h8000 + $urandom_range(32'h18000);
    endcase
  endfunction

  task automatic random_phase(int count);
    int sent, run_len;
    logic [15:0] step;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        // noise: a lone beat with any index
        send_step(16'($urandom), pick_size());
        sent++;
      end else begin
        // a well-formed run of steps, usually from the start
        step = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
        run_len = $urandom_range(3, 20);
        repeat (run_len) begin
          send_step(step, pick_size());
          step++;
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: first order at step zero, then saturation via extreme ratios,
    // then zero divisors and a maximal index.
    send_step(16'd0, 32'hFFFF_FFFF);
    send_step(16'd1, 32'd1);
    send_step(16'd2, 32'd0);
    send_step(16'd3, 32'h0001_0000);
    send_step(16'd4, 32'h0001_8000);
    send_step(16'd5, 32'h0000_C000);
    send_step(16'hFFFF, 32'h0002_0000);
    // first order only: held coefficients after step zero
    write_reg(CFG_MAX_ORDER, 32'd1);
    send_step(16'd7, 32'h0001_0000);
    send_step(16'd0, 32'h0001_0000);
    send_step(16'd9, 32'h0003_0000);
    // max order zero behaves as first order
    write_reg(CFG_MAX_ORDER, 32'd0);
    send_step(16'd3, 32'h0001_0000);
    send_step(16'd0, 32'h0000_8000);
    write_reg(CFG_MAX_ORDER, 32'd2);
    write_reg(CFG_INIT_STEP, 32'h0000_0000);
    send_step(16'd0, 32'h0001_0000);
    send_step(16'd1, 32'h0001_0000);
    send_step(16'd2, 32'h0000_4000);
    send_step(16'hFFFF, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_ORDER, 32'd3);
    write_reg(CFG_INIT_STEP, 32'hFFFF_FFFF);
    send_step(16'd0, 32'h0001_0000);
    send_step(16'd1, 32'h0001_0000);
    send_step(16'd2, 32'h0001_0000);
    send_step(16'd3, 32'h0000_0001);

    // Random phases: receiver idles more, then sender idles more, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      idle_in  = (phase == 0) ? 35 : (phase == 1) ? 51 : 0;
      idle_out = (phase == 0) ? 51 : (phase == 1) ? 35 : 0;
      write_reg(CFG_MAX_ORDER, $urandom_range(3));
      write_reg(CFG_INIT_STEP, pick_size());
      random_phase(ITEMS_PER_PHASE / 2);
      write_reg(CFG_MAX_ORDER, 32'd3);
      random_phase(ITEMS_PER_PHASE / 2);
    end

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** variable_step_bdf_ext_coefficients: PASSED **");
    end else begin
      $display("** variable_step_bdf_ext_coefficients: FAILED **");
    end
    $finish;
  end

endmodule
